// ===== design/dssa_pkg.sv =====
// types and constants shared by the sampler slot allocator
package dssa_pkg;

  localparam int POOL_SLOTS = 16;
  localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int SLOT_W     = 4;
  localparam int KEY_W      = 2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              filter_kind;
    logic              wrap_kind;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              reused;
    logic              pool_full;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] hint;
    logic [IDX_W-1:0] idx;
    logic             match;
    logic [IDX_W-1:0] match_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic             live;
    logic [KEY_W-1:0] key;
  } cell_wr_t;

endpackage

// ===== design/dssa_cell.sv =====
// one slot of the pool: live mark, key and a search token stage
module dssa_cell (
  input  logic            clk,
  input  logic            rst,
  input  dssa_pkg::tok_t  tok_in,
  output dssa_pkg::tok_t  tok_out,
  input  dssa_pkg::cell_wr_t wr,
  input  logic            sel
);
  import dssa_pkg::*;

  logic             live;
  logic [KEY_W-1:0] key;
  tok_t             tok_next;

  always_comb begin
    tok_next     = tok_in;
    tok_next.idx = tok_in.idx + IDX_W'(1);
    if (tok_in.valid) begin
      if (!tok_in.match && live && (key == tok_in.key)) begin
        tok_next.match     = 1'b1;
        tok_next.match_idx = tok_in.idx;
      end
      if (!tok_in.free && !live && (tok_in.idx >= tok_in.hint)) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = tok_in.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      live          <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && sel) begin
        live <= wr.live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && sel && wr.live) begin
      key <= wr.key;
    end
  end

endmodule

// ===== design/dedup_sampler_slot_allocator.sv =====
// top level of the sampler slot allocator: control, hint and the cell chain
// The pool is a row of POOL_SLOTS cells, one per slot. An allocate sends a
// search token down the row, one cell per cycle; the token picks up the
// lowest live slot with a matching key and the first free slot at or above
// the hint, and the new slot is claimed when the token leaves the last cell.
// An allocate's result waits on the token's walk through the seed register
// and every cell of the row; a release skips the walk and goes straight to
// the result state. One item is in work at a time; the result register lets
// the next item be accepted while a result still waits.
module dedup_sampler_slot_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dssa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dssa_pkg::rsp_t rsp
);
  import dssa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic [IDX_W-1:0]      hint;
  tok_t                  seed;
  tok_t                  chain [POOL_SLOTS+1];
  tok_t                  last;
  logic [POOL_SLOTS:0]   tok_live;
  cell_wr_t              wr;
  logic [IDX_W-1:0]      wr_idx;
  logic [POOL_SLOTS-1:0] wr_sel;
  rsp_t                  res;
  logic                  req_fire;
  logic                  rel_ok;
  logic [IDX_W-1:0]      rel_idx;
  logic                  scan_end;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rel_ok    = (32'(req.release_slot) < POOL_SLOTS);
  assign rel_idx   = IDX_W'(req.release_slot);
  assign last      = chain[POOL_SLOTS];
  assign scan_end  = (state == ST_SCAN) && last.valid;
  assign chain[0]  = seed;

  genvar i;
  generate
    for (i = 0; i < POOL_SLOTS; i++) begin : g_cell
      assign wr_sel[i] = (wr_idx == IDX_W'(i));
      dssa_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[i]),
        .tok_out (chain[i+1]),
        .wr      (wr),
        .sel     (wr_sel[i])
      );
    end
    for (i = 0; i <= POOL_SLOTS; i++) begin : g_live
      assign tok_live[i] = chain[i].valid;
    end
  endgenerate

  always_comb begin
    wr     = '0;
    wr_idx = '0;
    if (req_fire && (req.mode == MODE_RELEASE) && rel_ok) begin
      wr.en  = 1'b1;
      wr_idx = rel_idx;
    end else if (scan_end && !last.match && last.free) begin
      wr.en   = 1'b1;
      wr.live = 1'b1;
      wr.key  = last.key;
      wr_idx  = last.free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hint      <= '0;
      seed      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      seed.valid <= req_fire && (req.mode == MODE_ALLOC);
      if (req_fire) begin
        seed.key       <= {req.filter_kind, req.wrap_kind};
        seed.hint      <= hint;
        seed.idx       <= '0;
        seed.match     <= 1'b0;
        seed.match_idx <= '0;
        seed.free      <= 1'b0;
        seed.free_idx  <= '0;
      end
      if ((state == ST_DONE) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.mode == MODE_RELEASE) begin
              if (rel_ok && (rel_idx < hint)) begin
                hint <= rel_idx;
              end
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (last.valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && (req.mode == MODE_RELEASE)) begin
      res <= '{slot: req.release_slot, reused: 1'b0, pool_full: 1'b0};
    end else if (scan_end) begin
      if (last.match) begin
        res <= '{slot: SLOT_W'(last.match_idx), reused: 1'b1, pool_full: 1'b0};
      end else if (last.free) begin
        res <= '{slot: SLOT_W'(last.free_idx), reused: 1'b0, pool_full: 1'b0};
      end else begin
        res <= '{slot: '0, reused: 1'b0, pool_full: 1'b1};
      end
    end
    if ((state == ST_DONE) && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_live) <= 1)
    else $error("more than one search token in the chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (tok_live == '0))
    else $error("search token in flight while idle");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    scan_end |=> (state == ST_DONE))
    else $error("scan end did not reach result state");

  a_rsp_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.reused && rsp.pool_full))
    else $error("result both reused and full");

endmodule

// ===== bench/tb_dedup_sampler_slot_allocator.sv =====
// testbench for the sampler slot allocator: directed and random items against a pool predictor
module tb_dedup_sampler_slot_allocator;
  import dssa_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 30;
  localparam int MIXED_ITEMS  = 720;
  localparam int STREAM_ITEMS = 120;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // predicted pool state
  logic             slot_live [POOL_SLOTS];
  logic [KEY_W-1:0] slot_key_m [POOL_SLOTS];
  logic [IDX_W-1:0] first_free;

  rsp_t pending_rsp_q[$];
  int   mismatch_cnt;
  int   quiet_cycles;
  int   burst_left;
  int   stall_left;
  int   stall_pct;
  bit   idle_en;
  bit   valid_up;

  dedup_sampler_slot_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rsp_t predict_slot(input req_t r);
    rsp_t             res;
    logic [KEY_W-1:0] k;
    res = '0;
    k = {r.filter_kind, r.wrap_kind};
    if (r.mode == MODE_RELEASE) begin
      if (r.release_slot < POOL_SLOTS) begin
        slot_live[r.release_slot] = 1'b0;
        if (r.release_slot < first_free) first_free = IDX_W'(r.release_slot);
      end
      res.slot = r.release_slot;
      return res;
    end
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (slot_live[i] && slot_key_m[i] == k) begin
        res.slot = SLOT_W'(i);
        res.reused = 1'b1;
        return res;
      end
    end
    for (int i = int'(first_free); i < POOL_SLOTS; i++) begin
      if (!slot_live[i]) begin
        slot_live[i] = 1'b1;
        slot_key_m[i] = k;
        res.slot = SLOT_W'(i);
        return res;
      end
    end
    res.pool_full = 1'b1;
    return res;
  endfunction

  function automatic req_t make_req(input logic m, input logic f, input logic w,
                                    input int s);
    req_t r;
    r.mode = m;
    r.filter_kind = f;
    r.wrap_kind = w;
    r.release_slot = SLOT_W'(s);
    return r;
  endfunction

  // mostly allocates and releases of live slots, some releases anywhere
  function automatic req_t random_req();
    req_t r;
    int   pick;
    int   live_idx[$];
    r = make_req(MODE_ALLOC, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick >= 50) begin
      r.mode = MODE_RELEASE;
      if (pick < 85) begin
        for (int i = 0; i < POOL_SLOTS; i++)
          if (slot_live[i]) live_idx = {live_idx, i};
        if (live_idx.size() != 0)
          r.release_slot = SLOT_W'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
      end
    end
    return r;
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      req_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic send_item(input req_t r);
    int gap;
    req <= r;
    if (!valid_up) begin
      req_valid <= 1'b1;
      valid_up = 1'b1;
    end
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp_q = {pending_rsp_q, predict_slot(r)};
    if (idle_en) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 10);
        gap = $urandom_range(1, 24);
        lower_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    lower_valid();
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b0, 0));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b1, 15));
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b1, 0));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b0, 0));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b1, 0));
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b0, 15));
    send_item(make_req(MODE_RELEASE, 1'b0, 1'b0, 1));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b0, 0));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b1, 0));
    send_item(make_req(MODE_RELEASE, 1'b1, 1'b1, 15));
    send_item(make_req(MODE_RELEASE, 1'b0, 1'b0, 0));
    send_item(make_req(MODE_RELEASE, 1'b0, 1'b0, 0));
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b1, 0));
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b0, 0));
    send_item(make_req(MODE_RELEASE, 1'b0, 1'b1, 3));
    send_item(make_req(MODE_RELEASE, 1'b1, 1'b0, 2));
    send_item(make_req(MODE_ALLOC, 1'b0, 1'b1, 10));
    send_item(make_req(MODE_RELEASE, 1'b0, 1'b0, 10));
    send_item(make_req(MODE_RELEASE, 1'b1, 1'b1, 5));
    send_item(make_req(MODE_ALLOC, 1'b1, 1'b0, 5));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (STREAM_ITEMS) send_item(random_req());
    idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_mixed_traffic();
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      send_item(random_req());
      if (n % 200 == 199) wait_drained();
    end
  endtask

  // receiver stall pattern: stretches of random length, each with its own stall rate
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 80);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 95;
      endcase
    end else begin
      stall_left--;
    end
    rsp_stall <= idle_en && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: slot %0d reused %0b full %0b",
                   rsp.slot, rsp.reused, rsp.pool_full);
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp.slot !== e.slot || rsp.reused !== e.reused ||
            rsp.pool_full !== e.pool_full) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"result mismatch: expected slot %0d reused %0b full %0b, ",
                      "got slot %0d reused %0b full %0b"},
                     e.slot, e.reused, e.pool_full, rsp.slot, rsp.reused,
                     rsp.pool_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    burst_left = 0;
    stall_left = 0;
    stall_pct = 0;
    idle_en = 1'b1;
    valid_up = 1'b0;
    first_free = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_key_m[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_mixed_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_cnt += pending_rsp_q.size();
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dssa_pkg.sv
design/dssa_cell.sv
design/dedup_sampler_slot_allocator.sv
bench/tb_dedup_sampler_slot_allocator.sv
